FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL of the substring counter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge outside of reset.
`define WSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never be seen outside of reset.
`define WSC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define WSC_ASSERT(lbl, prop, msg)
`define WSC_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: rtl/wsc_pkg.sv
// Shared types, constants and register codes of the windowed substring counter.
`default_nettype none
package wsc_pkg;

  localparam int unsigned MAX_NEEDLE_BYTES_DEF = 16;
  localparam int unsigned POSITION_BITS_DEF    = 32;

  // Needle bytes held in the two needle words
  localparam int unsigned NEEDLE_REG_BYTES = 16;
  localparam int unsigned SIZE_W           = 5;
  localparam int unsigned COUNT_W          = 32;
  localparam int unsigned HAY_W            = 32;
  localparam int unsigned OFS_W            = 33;
  // Window bounds run from 0 to 2^32
  localparam int unsigned WIN_W            = 33;
  localparam int unsigned CFG_DATA_W       = 64;
  localparam int unsigned CFG_IDX_W        = 3;

  // Window resolution pipeline depth, input held off this long after a write
  localparam int unsigned SETTLE_CYCLES    = 4;
  localparam int unsigned SETTLE_W         = 3;

  localparam int unsigned QUEUE_DEPTH      = 4;

  typedef logic [7:0] byte_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEEDLE_LO    = 3'd0,
    REG_NEEDLE_HI    = 3'd1,
    REG_NEEDLE_SIZE  = 3'd2,
    REG_HAY_SIZE     = 3'd3,
    REG_START_OFFSET = 3'd4,
    REG_WIN_LENGTH   = 3'd5,
    REG_LENGTH_GIVEN = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_OFFSET = 2'd1,
    ST_BAD_LENGTH = 2'd2
  } status_e;

  // Resolved search window, [win_lo, win_hi)
  typedef struct packed {
    logic [WIN_W-1:0] win_lo;
    logic [WIN_W-1:0] win_hi;
    status_e          status;
  } win_t;

  // Needle summary for the matcher
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              usable;
  } ndl_t;

  // Classified item between front and back
  typedef struct packed {
    byte_t             data;
    logic              in_win;
    // window bytes up to and including this one, saturating
    logic [SIZE_W-1:0] run;
    logic              last;
    status_e           status;
  } qent_t;

endpackage
`default_nettype wire

FILE: rtl/wsc_cfg.sv
// Configuration registers, window resolution pipeline and needle alignment.
`default_nettype none
module wsc_cfg #(
  parameter int unsigned MAX_NEEDLE_BYTES = wsc_pkg::MAX_NEEDLE_BYTES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [wsc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [wsc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output wsc_pkg::win_t                        win_o,
  output wsc_pkg::ndl_t                        ndl_o,
  output wsc_pkg::byte_t                       needle_o [MAX_NEEDLE_BYTES],
  output logic [MAX_NEEDLE_BYTES-1:0]          mask_o,
  output logic                                 busy_o
);
  import wsc_pkg::*;

  localparam int unsigned SW = OFS_W + 2;

  logic [CFG_DATA_W-1:0] needle_lo_q, needle_hi_q;
  logic [SIZE_W-1:0]     size_q;
  logic [HAY_W-1:0]      hay_q;
  logic [OFS_W-1:0]      ofs_q, len_q;
  logic                  lg_q;
  logic [SETTLE_W-1:0]   settle_q;

  logic signed [SW-1:0]  ofs_s, len_s, hay_s;
  logic signed [SW-1:0]  ofs_res_q, remain_q, len_res_q, win_hi_s;
  logic                  ofs_bad_q;
  win_t                  win_d, win_q;

  logic [8*NEEDLE_REG_BYTES-1:0] nv;
  byte_t                         needle_d [MAX_NEEDLE_BYTES];
  byte_t                         needle_q [MAX_NEEDLE_BYTES];
  logic [MAX_NEEDLE_BYTES-1:0]   mask_d, mask_q;
  ndl_t                          ndl_d, ndl_q;

  // Register writes; any write restarts the settle count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_lo_q <= '0;
      needle_hi_q <= '0;
      size_q      <= '0;
      hay_q       <= '0;
      ofs_q       <= '0;
      len_q       <= '0;
      lg_q        <= 1'b0;
      settle_q    <= SETTLE_W'(SETTLE_CYCLES);
    end else begin
      if (cfg_we_i) begin
        settle_q <= SETTLE_W'(SETTLE_CYCLES);
        unique case (cfg_idx_i)
          REG_NEEDLE_LO:    needle_lo_q <= cfg_data_i;
          REG_NEEDLE_HI:    needle_hi_q <= cfg_data_i;
          REG_NEEDLE_SIZE:  size_q      <= cfg_data_i[SIZE_W-1:0];
          REG_HAY_SIZE:     hay_q       <= cfg_data_i[HAY_W-1:0];
          REG_START_OFFSET: ofs_q       <= cfg_data_i[OFS_W-1:0];
          REG_WIN_LENGTH:   len_q       <= cfg_data_i[OFS_W-1:0];
          REG_LENGTH_GIVEN: lg_q        <= cfg_data_i[0];
          default:          ;
        endcase
      end else if (settle_q != '0) begin
        settle_q <= settle_q - SETTLE_W'(1);
      end
    end
  end

  assign busy_o = (settle_q != '0);

  assign ofs_s = SW'(signed'(ofs_q));
  assign len_s = SW'(signed'(len_q));
  assign hay_s = signed'({{(SW-HAY_W){1'b0}}, hay_q});

  // Stage D: final status and exclusive window end
  assign win_hi_s = ofs_res_q + (lg_q ? len_res_q : remain_q);

  always_comb begin
    win_d.win_lo = ofs_res_q[WIN_W-1:0];
    win_d.win_hi = win_hi_s[WIN_W-1:0];
    if (ofs_bad_q) begin
      win_d.status = ST_BAD_OFFSET;
    end else if (lg_q && (len_res_q[SW-1] || (len_res_q > remain_q))) begin
      win_d.status = ST_BAD_LENGTH;
    end else begin
      win_d.status = ST_OK;
    end
  end

  // Needle aligned so that lane j faces the byte j places back in the window
  assign nv = {needle_hi_q, needle_lo_q};

  always_comb begin
    int k;
    k = 0;
    for (int j = 0; j < int'(MAX_NEEDLE_BYTES); j++) begin
      k = int'(size_q) - 1 - j;
      mask_d[j] = (j < int'(size_q));
      if (k >= 0 && k < int'(NEEDLE_REG_BYTES)) begin
        needle_d[j] = nv[8*k +: 8];
      end else begin
        needle_d[j] = '0;
      end
    end
    ndl_d.size   = size_q;
    ndl_d.usable = (size_q != '0) && (int'(size_q) <= int'(MAX_NEEDLE_BYTES));
  end

  // Resolution pipeline, one wide add per stage; reruns every cycle
  always_ff @(posedge clk_i) begin
    ofs_res_q <= ofs_s[SW-1] ? (ofs_s + hay_s) : ofs_s;
    ofs_bad_q <= ofs_res_q[SW-1] || (ofs_res_q > hay_s);
    remain_q  <= hay_s - ofs_res_q;
    len_res_q <= len_s[SW-1] ? (len_s + remain_q) : len_s;
    win_q     <= win_d;
    needle_q  <= needle_d;
    mask_q    <= mask_d;
    ndl_q     <= ndl_d;
  end

  assign win_o    = win_q;
  assign ndl_o    = ndl_q;
  assign needle_o = needle_q;
  assign mask_o   = mask_q;

endmodule
`default_nettype wire

FILE: rtl/wsc_front.sv
// Front end: takes input transactions, tracks position and classifies bytes.
`default_nettype none
module wsc_front #(
  parameter int unsigned POSITION_BITS = wsc_pkg::POSITION_BITS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire logic [7:0]     data_byte_i,
  input  wire logic           byte_present_i,
  input  wire logic           final_item_i,
  input  wsc_pkg::win_t       win_i,
  input  wire logic           busy_i,
  input  wire logic           q_full_i,
  output logic                q_push_o,
  output wsc_pkg::qent_t      q_data_o
);
  import wsc_pkg::*;

  localparam int unsigned CMP_W = (POSITION_BITS > WIN_W) ? POSITION_BITS : WIN_W;
  localparam int unsigned RUN_MAX = (1 << SIZE_W) - 1;

  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [CMP_W-1:0]         pos_c, pos_off;
  logic                     accept, consume;

  assign in_stall_o = busy_i || q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  // A byte counts only while the position counter has room
  assign consume = byte_present_i && (pos_q != {POSITION_BITS{1'b1}});
  assign pos_c   = CMP_W'(pos_q);
  // Distance from the window start, meaningful only inside the window
  assign pos_off = pos_c - CMP_W'(win_i.win_lo);

  always_comb begin
    q_data_o.data   = data_byte_i;
    q_data_o.last   = final_item_i;
    q_data_o.status = win_i.status;
    q_data_o.in_win = consume && (win_i.status == ST_OK) &&
                      (pos_c >= CMP_W'(win_i.win_lo)) && (pos_c < CMP_W'(win_i.win_hi));
    q_data_o.run    = (pos_off >= CMP_W'(RUN_MAX)) ? SIZE_W'(RUN_MAX) :
                      pos_off[SIZE_W-1:0] + SIZE_W'(1);
  end

  assign q_push_o = accept;

  // Position; cleared after the final transaction of a haystack
  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (final_item_i) begin
        pos_d = '0;
      end else if (consume) begin
        pos_d = pos_q + POSITION_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/wsc_queue.sv
// Short queue of classified items between front and back.
`default_nettype none
module wsc_queue #(
  parameter int unsigned DEPTH = wsc_pkg::QUEUE_DEPTH
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wsc_pkg::qent_t push_data_i,
  input  wire logic      pop_i,
  output wsc_pkg::qent_t head_o,
  output logic           full_o,
  output logic           empty_o
);
  import wsc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  qent_t            entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = entry_q[rd_ptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/wsc_back.sv
// Back end: byte history, parallel needle compare, counters and result register.
`default_nettype none
module wsc_back #(
  parameter int unsigned MAX_NEEDLE_BYTES = wsc_pkg::MAX_NEEDLE_BYTES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_empty_i,
  input  wsc_pkg::qent_t                     q_head_i,
  output logic                               q_pop_o,
  input  wsc_pkg::ndl_t                      ndl_i,
  input  wsc_pkg::byte_t                     needle_i [MAX_NEEDLE_BYTES],
  input  wire logic [MAX_NEEDLE_BYTES-1:0]   mask_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [wsc_pkg::COUNT_W-1:0]        match_count_o,
  output logic [1:0]                         status_o
);
  import wsc_pkg::*;

  localparam int unsigned NW = $clog2(MAX_NEEDLE_BYTES + 1);
  localparam int unsigned CW = (NW > SIZE_W) ? NW : SIZE_W;

  byte_t              recent_q [MAX_NEEDLE_BYTES];
  byte_t              recent_d [MAX_NEEDLE_BYTES];
  byte_t              shifted  [MAX_NEEDLE_BYTES];
  logic [NW-1:0]      gap_q, gap_d, gap_inc;
  logic [COUNT_W-1:0] found_q, found_d, found_upd, found_inc;
  logic               out_valid_q, out_valid_d;
  logic [COUNT_W-1:0] count_q;
  status_e            status_q;
  logic               all_eq, hit, emit;

  // Pop unless a result would have nowhere to go
  assign q_pop_o = !q_empty_i && (!q_head_i.last || !out_valid_q || !out_stall_i);
  assign emit    = q_pop_o && q_head_i.last;

  // Window history after taking this byte, newest in lane 0
  always_comb begin
    shifted[0] = q_head_i.data;
    for (int i = 1; i < int'(MAX_NEEDLE_BYTES); i++) begin
      shifted[i] = recent_q[i-1];
    end
  end

  assign gap_inc   = (gap_q == NW'(MAX_NEEDLE_BYTES)) ? gap_q : gap_q + NW'(1);
  assign found_inc = (found_q == {COUNT_W{1'b1}}) ? found_q : found_q + COUNT_W'(1);

  // Parallel compare of all lanes against the aligned needle
  always_comb begin
    all_eq = 1'b1;
    for (int j = 0; j < int'(MAX_NEEDLE_BYTES); j++) begin
      if (mask_i[j] && (shifted[j] != needle_i[j])) begin
        all_eq = 1'b0;
      end
    end
  end

  assign hit = ndl_i.usable && all_eq &&
               (q_head_i.run >= ndl_i.size) && (CW'(gap_inc) >= CW'(ndl_i.size));

  assign found_upd = (q_pop_o && q_head_i.in_win && hit) ? found_inc : found_q;

  // Stream state; a final item clears it for the next haystack
  always_comb begin
    recent_d = recent_q;
    gap_d    = gap_q;
    found_d  = found_upd;
    if (q_pop_o && q_head_i.in_win) begin
      recent_d = shifted;
      gap_d    = hit ? '0 : gap_inc;
    end
    if (emit) begin
      for (int i = 0; i < int'(MAX_NEEDLE_BYTES); i++) begin
        recent_d[i] = '0;
      end
      gap_d   = NW'(MAX_NEEDLE_BYTES);
      found_d = '0;
    end
  end

  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(MAX_NEEDLE_BYTES); i++) begin
        recent_q[i] <= '0;
      end
      gap_q       <= NW'(MAX_NEEDLE_BYTES);
      found_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      recent_q    <= recent_d;
      gap_q       <= gap_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      count_q  <= (q_head_i.status == ST_OK) ? found_upd : '0;
      status_q <= q_head_i.status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign match_count_o = count_q;
  assign status_o      = status_q;

endmodule
`default_nettype wire

FILE: rtl/windowed_substring_counter_core.sv
// Top level of the windowed substring counter.
//
//  channel | direction | handshake               | payload
//  in      | to core   | in_valid_i / in_stall_o | data_byte_i, byte_present_i, final_item_i
//  out     | from core | out_valid_o / out_stall_i | match_count_o, status_o
//  cfg     | to core   | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// One input transaction per cycle while in_stall_o is low; the result of a final item is
// written into the queue, then taken by the back end into the result register.
// The window is resolved in a four-stage pipeline from the registers, so the input is
// stalled after reset and after every configuration write until the window settles.
// A four-entry queue decouples the front end from output stalls; the input stalls
// only when it is full or while the window settles.
`default_nettype none
`include "assert_macros.svh"
module windowed_substring_counter_core #(
  parameter int unsigned MAX_NEEDLE_BYTES = wsc_pkg::MAX_NEEDLE_BYTES_DEF,
  parameter int unsigned POSITION_BITS    = wsc_pkg::POSITION_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [wsc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [wsc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [7:0]                     data_byte_i,
  input  wire logic                           byte_present_i,
  input  wire logic                           final_item_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [wsc_pkg::COUNT_W-1:0]         match_count_o,
  output logic [1:0]                          status_o
);
  import wsc_pkg::*;

  win_t                        win;
  ndl_t                        ndl;
  byte_t                       needle [MAX_NEEDLE_BYTES];
  logic [MAX_NEEDLE_BYTES-1:0] mask;
  logic                        busy;
  logic                        q_push, q_pop, q_full, q_empty;
  qent_t                       q_in, q_head;

  wsc_cfg #(
    .MAX_NEEDLE_BYTES(MAX_NEEDLE_BYTES)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .win_o      (win),
    .ndl_o      (ndl),
    .needle_o   (needle),
    .mask_o     (mask),
    .busy_o     (busy)
  );

  wsc_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .final_item_i   (final_item_i),
    .win_i          (win),
    .busy_i         (busy),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_data_o       (q_in)
  );

  wsc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  wsc_back #(
    .MAX_NEEDLE_BYTES(MAX_NEEDLE_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .ndl_i         (ndl),
    .needle_i      (needle),
    .mask_i        (mask),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .match_count_o (match_count_o),
    .status_o      (status_o)
  );

  // Checks
  `WSC_ASSERT(a_cfg_write_holds_input, cfg_we_i |=> in_stall_o, "input taken while window settles")
  `WSC_ASSERT(a_full_queue_stalls, q_full |-> in_stall_o, "input taken into a full queue")
  `WSC_ASSERT(a_result_from_final, $rose(out_valid_o) |-> $past(q_pop && q_head.last), "result without final item")
  `WSC_ASSERT_NEVER(a_status_code, out_valid_o && !(status_o == ST_OK || status_o == ST_BAD_OFFSET || status_o == ST_BAD_LENGTH), "undefined status code")

endmodule
`default_nettype wire
